// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray and sphere intersection: shared package
// Widths, codes and the structs that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package rsi_pkg;

   // Field widths.
   localparam int CRD_W  = 32;   // Q16.16 coordinate
   localparam int DIR_W  = 18;   // Q1.16 direction or normal
   localparam int RAD_W  = 31;   // radius
   localparam int OC_W   = 33;   // origin minus center
   localparam int HB_W   = 52;   // half_b, signed Q.32
   localparam int HBM_W  = 51;   // magnitude of half_b
   localparam int HBH_W  = 26;   // half of the magnitude for the partial products
   localparam int DSC_W  = 102;  // discriminant, Q.64
   localparam int ROOT_W = 51;   // floor square root of the discriminant
   localparam int X_W    = 53;   // root before rounding, Q.32
   localparam int T_W    = 40;   // root after rounding, Q.16
   localparam int PR_W   = 58;   // t times direction
   localparam int P_W    = 44;   // unsaturated hit point
   localparam int PC_W   = 45;   // point minus center
   localparam int M_W    = 61;   // scaled dividend for the normal
   localparam int REM_W  = 48;   // divider remainder
   localparam int QUO_W  = 17;   // divider quotient bits

   localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   // Command codes.
   localparam logic CMD_CLOSEST  = 1'b0;
   localparam logic CMD_INTERVAL = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [2:0][CRD_W-1:0]  org;
      logic [2:0][DIR_W-1:0]  dir;
      logic [CRD_W-1:0]       tmin;
      logic [CRD_W-1:0]       tmax;
   } ray_type;

   typedef struct packed {
      logic cmd;
      logic miss;
      logic near_in;
      logic far_in;
   } meta_type;

   // One word of the square root pipeline.
   typedef struct packed {
      ray_type              ray;
      logic [HB_W-1:0]      hb;
      logic                 miss;
      logic [DSC_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
   } sq_type;

   // One word of the normal divider pipeline, three axes side by side.
   typedef struct packed {
      meta_type               meta;
      logic [CRD_W-1:0]       tsat;
      logic [2:0][CRD_W-1:0]  psat;
      logic [2:0][DIR_W-1:0]  dir;
      logic [2:0]             neg;
      logic [2:0]             ovf;
      logic [2:0][REM_W-1:0]  rem;
      logic [2:0][QUO_W-1:0]  quo;
   } lane_type;

   typedef struct packed {
      meta_type               meta;
      logic [CRD_W-1:0]       tsat;
      logic [2:0][CRD_W-1:0]  psat;
      logic [2:0][DIR_W-1:0]  norm;
      logic                   front;
   } hit_type;

   typedef struct packed {
      logic                   hit;
      logic [CRD_W-1:0]       hit_dist;
      logic [2:0][CRD_W-1:0]  point;
      logic [2:0][DIR_W-1:0]  norm;
      logic                   front;
      logic                   last;
   } res_type;

   // Clamp a wide signed value to the 32-bit signed range.
   function automatic logic [CRD_W-1:0] sat32(input logic [P_W-1:0] x);
      logic [CRD_W-1:0] r;
      if ((&x[P_W-1:CRD_W-1]) || !(|x[P_W-1:CRD_W-1])) begin
         r = x[CRD_W-1:0];
      end else if (x[P_W-1]) begin
         r = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(CRD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- rtl/rsi_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// Square root stage
// Decides one bit of the floor square root of the discriminant by
// restoring subtraction.
// ----------------------------------------------------------------------------
module rsi_sqrt_stage #(
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_vld,
   input  rsi_pkg::sq_type in_word,
   output logic            out_vld,
   output rsi_pkg::sq_type out_word
);

   logic            vld_ff;
   rsi_pkg::sq_type word_ff;
   rsi_pkg::sq_type word_in;
   logic [rsi_pkg::DSC_W:0] trial;
   logic [rsi_pkg::DSC_W:0] rem_ext;

   // Candidate bit: (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT).
   always_comb begin
      trial   = ((rsi_pkg::DSC_W+1)'(in_word.root) << (BIT + 1))
              | ((rsi_pkg::DSC_W+1)'(1) << (2 * BIT));
      rem_ext = {1'b0, in_word.rem};
      word_in = in_word;
      if (rem_ext >= trial) begin
         word_in.rem       = in_word.rem - trial[rsi_pkg::DSC_W-1:0];
         word_in.root[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_word = word_ff;

endmodule

// ----- rtl/rsi_div_stage.sv -----
// ----------------------------------------------------------------------------
// Normal divider stage
// Decides one quotient bit of |p - c| * 2^16 / r for all three axes.
// ----------------------------------------------------------------------------
module rsi_div_stage #(
   parameter int BIT = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [rsi_pkg::RAD_W-1:0]  radius,
   input  logic                       in_vld,
   input  rsi_pkg::lane_type          in_word,
   output logic                       out_vld,
   output rsi_pkg::lane_type          out_word
);

   logic              vld_ff;
   rsi_pkg::lane_type word_ff;
   rsi_pkg::lane_type word_in;
   logic [rsi_pkg::REM_W-1:0] trial;

   // Restoring step on each axis against the shifted radius.
   always_comb begin
      trial   = rsi_pkg::REM_W'(radius) << BIT;
      word_in = in_word;
      for (int k = 0; k < 3; k++) begin
         if (in_word.rem[k] >= trial) begin
            word_in.rem[k]      = in_word.rem[k] - trial;
            word_in.quo[k][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_word = word_ff;

endmodule

// ----- rtl/rsi_hit_lane.sv -----
// ----------------------------------------------------------------------------
// Hit lane
// From one root t: the hit point, the unit normal by a pipelined divider,
// the face test and the saturated outputs.
// ----------------------------------------------------------------------------
module rsi_hit_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic [2:0][rsi_pkg::CRD_W-1:0]      center,
   input  logic [rsi_pkg::RAD_W-1:0]           radius,
   input  logic                                in_vld,
   input  rsi_pkg::meta_type                   in_meta,
   input  logic [2:0][rsi_pkg::CRD_W-1:0]      in_org,
   input  logic [2:0][rsi_pkg::DIR_W-1:0]      in_dir,
   input  logic [rsi_pkg::T_W-1:0]             in_t,
   output logic                                out_vld,
   output rsi_pkg::hit_type                    out_hit
);

   localparam int DIV_N = rsi_pkg::QUO_W;

   // Stage 1: t times direction.
   logic                                   l1_vld_ff;
   rsi_pkg::meta_type                      l1_meta_ff;
   logic [2:0][rsi_pkg::CRD_W-1:0]         l1_org_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l1_dir_ff;
   logic [rsi_pkg::T_W-1:0]                l1_t_ff;
   logic [2:0][rsi_pkg::PR_W-1:0]          l1_prod_ff;
   logic [2:0][rsi_pkg::PR_W-1:0]          l1_prod_in;

   // Stage 2: unsaturated point.
   logic                                   l2_vld_ff;
   rsi_pkg::meta_type                      l2_meta_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l2_dir_ff;
   logic [rsi_pkg::T_W-1:0]                l2_t_ff;
   logic [2:0][rsi_pkg::P_W-1:0]           l2_p_ff;
   logic [2:0][rsi_pkg::P_W-1:0]           l2_p_in;

   // Stage 3: point minus center, saturation.
   logic                                   l3_vld_ff;
   rsi_pkg::meta_type                      l3_meta_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l3_dir_ff;
   logic [rsi_pkg::CRD_W-1:0]              l3_tsat_ff;
   logic [2:0][rsi_pkg::CRD_W-1:0]         l3_psat_ff;
   logic [2:0][rsi_pkg::PC_W-1:0]          l3_pc_ff;
   logic [2:0][rsi_pkg::PC_W-1:0]          l3_pc_in;

   // Stage 4: scaled dividend with half the radius added for rounding.
   logic                                   l4_vld_ff;
   rsi_pkg::meta_type                      l4_meta_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l4_dir_ff;
   logic [rsi_pkg::CRD_W-1:0]              l4_tsat_ff;
   logic [2:0][rsi_pkg::CRD_W-1:0]         l4_psat_ff;
   logic [2:0]                             l4_neg_ff;
   logic [2:0][rsi_pkg::M_W-1:0]           l4_m_ff;
   logic [2:0][rsi_pkg::M_W-1:0]           l4_m_in;

   // Stage 5: overflow check, divider entry.
   logic                                   l5_vld_ff;
   rsi_pkg::lane_type                      l5_word_ff;
   rsi_pkg::lane_type                      l5_word_in;

   logic              div_vld  [0:DIV_N];
   rsi_pkg::lane_type div_word [0:DIV_N];

   // Stage 6: clamped, signed normal.
   logic                                   l6_vld_ff;
   rsi_pkg::meta_type                      l6_meta_ff;
   logic [rsi_pkg::CRD_W-1:0]              l6_tsat_ff;
   logic [2:0][rsi_pkg::CRD_W-1:0]         l6_psat_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l6_dir_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l6_n_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l6_n_in;

   // Stage 7: direction times normal.
   logic                                   l7_vld_ff;
   rsi_pkg::meta_type                      l7_meta_ff;
   logic [rsi_pkg::CRD_W-1:0]              l7_tsat_ff;
   logic [2:0][rsi_pkg::CRD_W-1:0]         l7_psat_ff;
   logic [2:0][rsi_pkg::DIR_W-1:0]         l7_n_ff;
   logic [2:0][2*rsi_pkg::DIR_W-1:0]       l7_dp_ff;
   logic [2:0][2*rsi_pkg::DIR_W-1:0]       l7_dp_in;

   // Stage 8: face test and final normal.
   logic                                   l8_vld_ff;
   rsi_pkg::hit_type                       l8_hit_ff;
   rsi_pkg::hit_type                       l8_hit_in;
   logic signed [2*rsi_pkg::DIR_W+1:0]     dot;

   // Stage 1 logic.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         l1_prod_in[k] = rsi_pkg::PR_W'($signed(in_t) * $signed(in_dir[k]));
      end
   end

   // Stage 2 logic: origin plus t*d rounded to Q16.16, halves up.
   always_comb begin
      logic signed [rsi_pkg::PR_W:0] rnd;
      for (int k = 0; k < 3; k++) begin
         rnd = $signed({l1_prod_ff[k][rsi_pkg::PR_W-1], l1_prod_ff[k]})
             + (rsi_pkg::PR_W+1)'(32768);
         l2_p_in[k] = rsi_pkg::P_W'($signed(l1_org_ff[k]))
                    + rsi_pkg::P_W'(rnd >>> 16);
      end
   end

   // Stage 3 logic.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         l3_pc_in[k] = rsi_pkg::PC_W'($signed(l2_p_ff[k]))
                     - rsi_pkg::PC_W'($signed(center[k]));
      end
   end

   // Stage 4 logic.
   always_comb begin
      logic [rsi_pkg::PC_W-1:0] pcm;
      for (int k = 0; k < 3; k++) begin
         pcm = l3_pc_ff[k][rsi_pkg::PC_W-1] ? -l3_pc_ff[k] : l3_pc_ff[k];
         l4_m_in[k] = rsi_pkg::M_W'({pcm[rsi_pkg::PC_W-2:0], 16'b0})
                    + rsi_pkg::M_W'(radius[rsi_pkg::RAD_W-1:1]);
      end
   end

   // Stage 5 logic: a quotient of 2^17 or more is clamped anyway.
   always_comb begin
      l5_word_in.meta = l4_meta_ff;
      l5_word_in.tsat = l4_tsat_ff;
      l5_word_in.psat = l4_psat_ff;
      l5_word_in.dir  = l4_dir_ff;
      l5_word_in.neg  = l4_neg_ff;
      for (int k = 0; k < 3; k++) begin
         l5_word_in.ovf[k] = l4_m_ff[k] >= (rsi_pkg::M_W'(radius) << rsi_pkg::QUO_W);
         l5_word_in.rem[k] = l4_m_ff[k][rsi_pkg::REM_W-1:0];
         l5_word_in.quo[k] = '0;
      end
   end

   // Stages 1 to 5 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff <= 1'b0;
         l2_vld_ff <= 1'b0;
         l3_vld_ff <= 1'b0;
         l4_vld_ff <= 1'b0;
         l5_vld_ff <= 1'b0;
      end else if (en) begin
         l1_vld_ff <= in_vld;
         l2_vld_ff <= l1_vld_ff;
         l3_vld_ff <= l2_vld_ff;
         l4_vld_ff <= l3_vld_ff;
         l5_vld_ff <= l4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_meta_ff <= in_meta;
         l1_org_ff  <= in_org;
         l1_dir_ff  <= in_dir;
         l1_t_ff    <= in_t;
         l1_prod_ff <= l1_prod_in;
         l2_meta_ff <= l1_meta_ff;
         l2_dir_ff  <= l1_dir_ff;
         l2_t_ff    <= l1_t_ff;
         l2_p_ff    <= l2_p_in;
         l3_meta_ff <= l2_meta_ff;
         l3_dir_ff  <= l2_dir_ff;
         l3_tsat_ff <= rsi_pkg::sat32(rsi_pkg::P_W'($signed(l2_t_ff)));
         for (int k = 0; k < 3; k++) begin
            l3_psat_ff[k] <= rsi_pkg::sat32(l2_p_ff[k]);
         end
         l3_pc_ff   <= l3_pc_in;
         l4_meta_ff <= l3_meta_ff;
         l4_dir_ff  <= l3_dir_ff;
         l4_tsat_ff <= l3_tsat_ff;
         l4_psat_ff <= l3_psat_ff;
         for (int k = 0; k < 3; k++) begin
            l4_neg_ff[k] <= l3_pc_ff[k][rsi_pkg::PC_W-1];
         end
         l4_m_ff    <= l4_m_in;
         l5_word_ff <= l5_word_in;
      end
   end

   // Divider: one quotient bit per stage, most significant first.
   assign div_vld[0]  = l5_vld_ff;
   assign div_word[0] = l5_word_ff;

   for (genvar g = 0; g < DIV_N; g++) begin : g_div
      rsi_div_stage #(
         .BIT (DIV_N - 1 - g)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .radius   (radius),
         .in_vld   (div_vld[g]),
         .in_word  (div_word[g]),
         .out_vld  (div_vld[g+1]),
         .out_word (div_word[g+1])
      );
   end

   // Stage 6 logic: clamp to one, then apply the sign.
   always_comb begin
      logic [rsi_pkg::QUO_W-1:0] q;
      for (int k = 0; k < 3; k++) begin
         if (div_word[DIV_N].ovf[k] || div_word[DIV_N].quo[k] > rsi_pkg::ONE_Q16) begin
            q = rsi_pkg::ONE_Q16;
         end else begin
            q = div_word[DIV_N].quo[k];
         end
         l6_n_in[k] = div_word[DIV_N].neg[k] ? -{1'b0, q} : {1'b0, q};
      end
   end

   // Stage 7 logic.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         l7_dp_in[k] = $signed(l6_dir_ff[k]) * $signed(l6_n_ff[k]);
      end
   end

   // Stage 8 logic: a grazing ray counts as back face.
   always_comb begin
      dot = (2*rsi_pkg::DIR_W+2)'($signed(l7_dp_ff[0]))
          + (2*rsi_pkg::DIR_W+2)'($signed(l7_dp_ff[1]))
          + (2*rsi_pkg::DIR_W+2)'($signed(l7_dp_ff[2]));
      l8_hit_in.meta  = l7_meta_ff;
      l8_hit_in.tsat  = l7_tsat_ff;
      l8_hit_in.psat  = l7_psat_ff;
      l8_hit_in.front = dot[2*rsi_pkg::DIR_W+1];
      for (int k = 0; k < 3; k++) begin
         l8_hit_in.norm[k] = l8_hit_in.front ? l7_n_ff[k] : -l7_n_ff[k];
      end
   end

   // Stages 6 to 8 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         l6_vld_ff <= 1'b0;
         l7_vld_ff <= 1'b0;
         l8_vld_ff <= 1'b0;
      end else if (en) begin
         l6_vld_ff <= div_vld[DIV_N];
         l7_vld_ff <= l6_vld_ff;
         l8_vld_ff <= l7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l6_meta_ff <= div_word[DIV_N].meta;
         l6_tsat_ff <= div_word[DIV_N].tsat;
         l6_psat_ff <= div_word[DIV_N].psat;
         l6_dir_ff  <= div_word[DIV_N].dir;
         l6_n_ff    <= l6_n_in;
         l7_meta_ff <= l6_meta_ff;
         l7_tsat_ff <= l6_tsat_ff;
         l7_psat_ff <= l6_psat_ff;
         l7_n_ff    <= l6_n_ff;
         l7_dp_ff   <= l7_dp_in;
         l8_hit_ff  <= l8_hit_in;
      end
   end

   assign out_vld = l8_vld_ff;
   assign out_hit = l8_hit_ff;

endmodule

// ----- rtl/ray_sphere_intersect.sv -----
// ----------------------------------------------------------------------------
// Ray and sphere intersection
// Tests each ray against a configured sphere and returns the closest hit
// in a window, or the entry and exit hits, with point, normal and face.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    ray word, cmd in req_tuser
//   rsp      out        rsp_tvalid/tready    hit word, hit in rsp_tuser
//   csr      in         csr_valid/ready      register index and data
//
// One ray word is taken per cycle unless rsp stalls; an interval ray gives
// two words and so holds the pipeline while its exit word waits behind the
// entry word at the output register. On its way to the first result word
// a ray passes 8 setup stages, 51 square root stages, 2 root stages and
// the hit lanes, the 17 divider stages included, then the output register.
// Reset is synchronous; it clears the valid bits and sets the sphere to
// the unit sphere at the origin. A stall on rsp freezes the whole pipeline.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
   input  logic          clock,
   input  logic          reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max, pad
   input  logic [215:0]  req_tdata,
   input  logic          req_tuser,   // cmd
   input  logic          req_tvalid,
   output logic          req_tready,
   // hit_distance, point_x, point_y, point_z, normal_x, normal_y,
   // normal_z, front_face, pad
   output logic [183:0]  rsp_tdata,
   output logic          rsp_tuser,   // hit
   output logic          rsp_tlast,   // last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int CW = rsi_pkg::CRD_W;

   // Configuration registers.
   logic [CW-1:0]              center_x_ff;
   logic [CW-1:0]              center_y_ff;
   logic [CW-1:0]              center_z_ff;
   logic [rsi_pkg::RAD_W-1:0]  radius_ff;
   logic [2:0][CW-1:0]         center;

   logic en;
   rsi_pkg::ray_type ray_in;

   // Setup stages.
   logic                              s1_vld_ff;
   rsi_pkg::ray_type                  s1_ray_ff;
   logic [2:0][rsi_pkg::OC_W-1:0]     s1_oc_ff;
   logic [2:0][rsi_pkg::OC_W-1:0]     s1_oc_in;

   logic                              s2_vld_ff;
   rsi_pkg::ray_type                  s2_ray_ff;
   logic [2:0][rsi_pkg::HB_W-1:0]     s2_hbp_ff;
   logic [2:0][2*CW-1:0]              s2_sqp_ff;
   logic [2*rsi_pkg::RAD_W-1:0]       s2_r2_ff;
   logic [2:0][rsi_pkg::HB_W-1:0]     s2_hbp_in;
   logic [2:0][2*CW-1:0]              s2_sqp_in;

   logic                              s3_vld_ff;
   rsi_pkg::ray_type                  s3_ray_ff;
   logic [rsi_pkg::HB_W-1:0]          s3_hb_ff;
   logic [2*CW+1:0]                   s3_sq_ff;
   logic [2*rsi_pkg::RAD_W-1:0]       s3_r2_ff;

   logic                              s4_vld_ff;
   rsi_pkg::ray_type                  s4_ray_ff;
   logic [rsi_pkg::HB_W-1:0]          s4_hb_ff;
   logic [rsi_pkg::HBM_W-1:0]         s4_hbm_ff;
   logic [2*CW+1:0]                   s4_sq_ff;
   logic [2*rsi_pkg::RAD_W-1:0]       s4_r2_ff;

   logic                              s5_vld_ff;
   rsi_pkg::ray_type                  s5_ray_ff;
   logic [rsi_pkg::HB_W-1:0]          s5_hb_ff;
   logic [2*rsi_pkg::HBH_W-1:0]       s5_hh_ff;
   logic [2*rsi_pkg::HBH_W-1:0]       s5_hm_ff;
   logic [2*rsi_pkg::HBH_W-1:0]       s5_hl_ff;
   logic [2*CW+1:0]                   s5_sq_ff;
   logic [2*rsi_pkg::RAD_W-1:0]       s5_r2_ff;

   logic                              s6_vld_ff;
   rsi_pkg::ray_type                  s6_ray_ff;
   logic [rsi_pkg::HB_W-1:0]          s6_hb_ff;
   logic [rsi_pkg::DSC_W-1:0]         s6_hb2_ff;
   logic [2*CW+1:0]                   s6_sq_ff;
   logic [2*rsi_pkg::RAD_W-1:0]       s6_r2_ff;

   logic                              s7_vld_ff;
   rsi_pkg::ray_type                  s7_ray_ff;
   logic [rsi_pkg::HB_W-1:0]          s7_hb_ff;
   logic [rsi_pkg::DSC_W-1:0]         s7_lhs_ff;
   logic [rsi_pkg::DSC_W-1:0]         s7_rhs_ff;

   logic                              s8_vld_ff;
   rsi_pkg::sq_type                   s8_word_ff;
   rsi_pkg::sq_type                   s8_word_in;
   logic [rsi_pkg::DSC_W:0]           disc_ext;

   // Square root chain.
   logic            sq_vld  [0:rsi_pkg::ROOT_W];
   rsi_pkg::sq_type sq_word [0:rsi_pkg::ROOT_W];

   // Root stages.
   logic                              s9_vld_ff;
   rsi_pkg::ray_type                  s9_ray_ff;
   logic                              s9_miss_ff;
   logic [rsi_pkg::X_W-1:0]           s9_xn_ff;
   logic [rsi_pkg::X_W-1:0]           s9_xf_ff;

   logic                              s10_vld_ff;
   rsi_pkg::ray_type                  s10_ray_ff;
   rsi_pkg::meta_type                 s10_meta_ff;
   rsi_pkg::meta_type                 s10_meta_in;
   logic [rsi_pkg::T_W-1:0]           s10_tn_ff;
   logic [rsi_pkg::T_W-1:0]           s10_tf_ff;
   logic [rsi_pkg::T_W-1:0]           tn_in;
   logic [rsi_pkg::T_W-1:0]           tf_in;

   // Lane outputs.
   logic             h0_vld;
   logic             h1_vld;
   rsi_pkg::hit_type h0;
   rsi_pkg::hit_type h1;

   // Output register and the held second word of an interval.
   logic             cur_vld_ff;
   rsi_pkg::res_type cur_ff;
   logic             pend_vld_ff;
   rsi_pkg::res_type pend_ff;
   rsi_pkg::res_type first_word;
   rsi_pkg::res_type second_word;
   logic             two_words;

   function automatic rsi_pkg::res_type make_hit(input rsi_pkg::hit_type h,
                                                 input logic last);
      rsi_pkg::res_type r;
      r.hit      = 1'b1;
      r.hit_dist = h.tsat;
      r.point    = h.psat;
      r.norm     = h.norm;
      r.front    = h.front;
      r.last     = last;
      return r;
   endfunction

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= rsi_pkg::RAD_W'(65536);
      end else if (csr_valid) begin
         case (csr_index)
            rsi_pkg::REG_CENTER_X: center_x_ff <= csr_data;
            rsi_pkg::REG_CENTER_Y: center_y_ff <= csr_data;
            rsi_pkg::REG_CENTER_Z: center_z_ff <= csr_data;
            rsi_pkg::REG_RADIUS:   radius_ff   <= csr_data[rsi_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign center = {center_z_ff, center_y_ff, center_x_ff};

   // The whole pipeline moves when the output register can take a word.
   assign en         = !cur_vld_ff || (rsp_tready && !pend_vld_ff);
   assign req_tready = en;

   // Input word unpacking.
   always_comb begin
      ray_in.cmd    = req_tuser;
      ray_in.org[0] = req_tdata[31:0];
      ray_in.org[1] = req_tdata[63:32];
      ray_in.org[2] = req_tdata[95:64];
      ray_in.dir[0] = req_tdata[113:96];
      ray_in.dir[1] = req_tdata[131:114];
      ray_in.dir[2] = req_tdata[149:132];
      ray_in.tmin   = req_tdata[181:150];
      ray_in.tmax   = req_tdata[213:182];
   end

   // Stage 1 and 2 logic: origin minus center, then the products.
   always_comb begin
      logic [rsi_pkg::OC_W-1:0] ocm;
      for (int k = 0; k < 3; k++) begin
         s1_oc_in[k] = rsi_pkg::OC_W'($signed(ray_in.org[k]))
                     - rsi_pkg::OC_W'($signed(center[k]));
         s2_hbp_in[k] = rsi_pkg::HB_W'($signed(s1_oc_ff[k]) * $signed(s1_ray_ff.dir[k]));
         ocm = s1_oc_ff[k][rsi_pkg::OC_W-1] ? -s1_oc_ff[k] : s1_oc_ff[k];
         s2_sqp_in[k] = ocm[CW-1:0] * ocm[CW-1:0];
      end
   end

   // Stage 8 logic: discriminant and the miss decision.
   always_comb begin
      disc_ext = {1'b0, s7_lhs_ff} - {1'b0, s7_rhs_ff};
      s8_word_in.ray  = s7_ray_ff;
      s8_word_in.hb   = s7_hb_ff;
      s8_word_in.miss = disc_ext[rsi_pkg::DSC_W] || (radius_ff == '0);
      s8_word_in.rem  = disc_ext[rsi_pkg::DSC_W-1:0];
      s8_word_in.root = '0;
   end

   // Setup stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ray_ff <= ray_in;
         s1_oc_ff  <= s1_oc_in;

         s2_ray_ff <= s1_ray_ff;
         s2_hbp_ff <= s2_hbp_in;
         s2_sqp_ff <= s2_sqp_in;
         s2_r2_ff  <= radius_ff * radius_ff;

         // Sums of the three axes.
         s3_ray_ff <= s2_ray_ff;
         s3_hb_ff  <= s2_hbp_ff[0] + s2_hbp_ff[1] + s2_hbp_ff[2];
         s3_sq_ff  <= (2*CW+2)'(s2_sqp_ff[0]) + (2*CW+2)'(s2_sqp_ff[1])
                    + (2*CW+2)'(s2_sqp_ff[2]);
         s3_r2_ff  <= s2_r2_ff;

         // Magnitude of half_b.
         s4_ray_ff <= s3_ray_ff;
         s4_hb_ff  <= s3_hb_ff;
         s4_hbm_ff <= s3_hb_ff[rsi_pkg::HB_W-1] ? rsi_pkg::HBM_W'(-s3_hb_ff)
                                               : rsi_pkg::HBM_W'(s3_hb_ff);
         s4_sq_ff  <= s3_sq_ff;
         s4_r2_ff  <= s3_r2_ff;

         // Partial products of half_b squared.
         s5_ray_ff <= s4_ray_ff;
         s5_hb_ff  <= s4_hb_ff;
         s5_hh_ff  <= s4_hbm_ff[rsi_pkg::HBM_W-1:rsi_pkg::HBH_W]
                    * s4_hbm_ff[rsi_pkg::HBM_W-1:rsi_pkg::HBH_W];
         s5_hm_ff  <= s4_hbm_ff[rsi_pkg::HBM_W-1:rsi_pkg::HBH_W]
                    * s4_hbm_ff[rsi_pkg::HBH_W-1:0];
         s5_hl_ff  <= s4_hbm_ff[rsi_pkg::HBH_W-1:0] * s4_hbm_ff[rsi_pkg::HBH_W-1:0];
         s5_sq_ff  <= s4_sq_ff;
         s5_r2_ff  <= s4_r2_ff;

         // half_b squared.
         s6_ray_ff <= s5_ray_ff;
         s6_hb_ff  <= s5_hb_ff;
         s6_hb2_ff <= (rsi_pkg::DSC_W'(s5_hh_ff) << (2*rsi_pkg::HBH_W))
                    + (rsi_pkg::DSC_W'(s5_hm_ff) << (rsi_pkg::HBH_W + 1))
                    + rsi_pkg::DSC_W'(s5_hl_ff);
         s6_sq_ff  <= s5_sq_ff;
         s6_r2_ff  <= s5_r2_ff;

         // Both sides of the discriminant in Q.64.
         s7_ray_ff <= s6_ray_ff;
         s7_hb_ff  <= s6_hb_ff;
         s7_lhs_ff <= s6_hb2_ff + (rsi_pkg::DSC_W'(s6_r2_ff) << CW);
         s7_rhs_ff <= rsi_pkg::DSC_W'(s6_sq_ff) << CW;

         s8_word_ff <= s8_word_in;
      end
   end

   // Square root, one bit per stage.
   assign sq_vld[0]  = s8_vld_ff;
   assign sq_word[0] = s8_word_ff;

   for (genvar g = 0; g < rsi_pkg::ROOT_W; g++) begin : g_sqrt
      rsi_sqrt_stage #(
         .BIT (rsi_pkg::ROOT_W - 1 - g)
      ) u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (sq_vld[g]),
         .in_word  (sq_word[g]),
         .out_vld  (sq_vld[g+1]),
         .out_word (sq_word[g+1])
      );
   end

   // Stage 10 logic: round both roots, halves up, and test the window.
   always_comb begin
      logic [rsi_pkg::X_W-1:0] rn;
      logic [rsi_pkg::X_W-1:0] rf;
      logic [rsi_pkg::T_W-1:0] lo;
      logic [rsi_pkg::T_W-1:0] hi;
      rn    = s9_xn_ff + rsi_pkg::X_W'(32768);
      rf    = s9_xf_ff + rsi_pkg::X_W'(32768);
      tn_in = rsi_pkg::T_W'($signed(rn) >>> 16);
      tf_in = rsi_pkg::T_W'($signed(rf) >>> 16);
      lo    = rsi_pkg::T_W'($signed(s9_ray_ff.tmin));
      hi    = rsi_pkg::T_W'($signed(s9_ray_ff.tmax));
      s10_meta_in.cmd     = s9_ray_ff.cmd;
      s10_meta_in.miss    = s9_miss_ff;
      s10_meta_in.near_in = ($signed(tn_in) >= $signed(lo)) && ($signed(tn_in) <= $signed(hi));
      s10_meta_in.far_in  = ($signed(tf_in) >= $signed(lo)) && ($signed(tf_in) <= $signed(hi));
   end

   // Root stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff  <= sq_vld[rsi_pkg::ROOT_W];
         s10_vld_ff <= s9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_ray_ff   <= sq_word[rsi_pkg::ROOT_W].ray;
         s9_miss_ff  <= sq_word[rsi_pkg::ROOT_W].miss;
         s9_xn_ff    <= -rsi_pkg::X_W'($signed(sq_word[rsi_pkg::ROOT_W].hb))
                      - rsi_pkg::X_W'(sq_word[rsi_pkg::ROOT_W].root);
         s9_xf_ff    <= -rsi_pkg::X_W'($signed(sq_word[rsi_pkg::ROOT_W].hb))
                      + rsi_pkg::X_W'(sq_word[rsi_pkg::ROOT_W].root);
         s10_ray_ff  <= s9_ray_ff;
         s10_meta_ff <= s10_meta_in;
         s10_tn_ff   <= tn_in;
         s10_tf_ff   <= tf_in;
      end
   end

   // Hit lanes for the nearer and the farther root.
   rsi_hit_lane u_lane_near (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .center  (center),
      .radius  (radius_ff),
      .in_vld  (s10_vld_ff),
      .in_meta (s10_meta_ff),
      .in_org  (s10_ray_ff.org),
      .in_dir  (s10_ray_ff.dir),
      .in_t    (s10_tn_ff),
      .out_vld (h0_vld),
      .out_hit (h0)
   );

   rsi_hit_lane u_lane_far (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .center  (center),
      .radius  (radius_ff),
      .in_vld  (s10_vld_ff),
      .in_meta (s10_meta_ff),
      .in_org  (s10_ray_ff.org),
      .in_dir  (s10_ray_ff.dir),
      .in_t    (s10_tf_ff),
      .out_vld (h1_vld),
      .out_hit (h1)
   );

   // Result selection: a miss is one word with only last set.
   always_comb begin
      first_word      = '0;
      first_word.last = 1'b1;
      second_word     = first_word;
      two_words       = 1'b0;
      if (!h0.meta.miss) begin
         if (h0.meta.cmd == rsi_pkg::CMD_INTERVAL) begin
            first_word  = make_hit(h0, 1'b0);
            second_word = make_hit(h1, 1'b1);
            two_words   = 1'b1;
         end else if (h0.meta.near_in) begin
            first_word = make_hit(h0, 1'b1);
         end else if (h0.meta.far_in) begin
            first_word = make_hit(h1, 1'b1);
         end
      end
   end

   // Output register with the held exit word.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else if (cur_vld_ff && rsp_tready && pend_vld_ff) begin
         pend_vld_ff <= 1'b0;
      end else if (en) begin
         cur_vld_ff  <= h0_vld;
         pend_vld_ff <= h0_vld && two_words;
      end
   end

   always_ff @(posedge clock) begin
      if (cur_vld_ff && rsp_tready && pend_vld_ff) begin
         cur_ff <= pend_ff;
      end else if (en) begin
         cur_ff  <= first_word;
         pend_ff <= second_word;
      end
   end

   assign rsp_tvalid = cur_vld_ff;
   assign rsp_tuser  = cur_ff.hit;
   assign rsp_tlast  = cur_ff.last;
   assign rsp_tdata  = {1'b0, cur_ff.front, cur_ff.norm[2], cur_ff.norm[1],
                        cur_ff.norm[0], cur_ff.point[2], cur_ff.point[1],
                        cur_ff.point[0], cur_ff.hit_dist};

   // A held exit word always sits behind a shown entry word.
   a_pend_behind_cur: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> cur_vld_ff)
      else $error("exit word held without an entry word");

   // The entry word of a pair is a hit and never the last word.
   a_pair_entry: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (rsp_tuser && !rsp_tlast))
      else $error("entry word of an interval is malformed");

   // A miss is always the only word for its ray.
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && !pend_vld_ff))
      else $error("miss word not marked last");

endmodule

// ----- bench/ray_sphere_intersect_tb.sv -----
// ----------------------------------------------------------------------------
// Ray and sphere intersection: testbench
// Drives rays and sphere settings into the block and checks every result
// word against an independent fixed-point predictor of the intersection.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 87;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_RAYS = 1488;

   // Expected result word.
   typedef struct {
      logic             hit;
      logic [31:0]      hit_dist;
      logic [31:0]      px, py, pz;
      logic [17:0]      nx, ny, nz;
      logic             front;
      logic             last;
   } hit_word_type;

   // One ray for the directed table.
   typedef struct {
      logic             cmd;
      logic [31:0]      ox, oy, oz;
      logic [17:0]      dx, dy, dz;
      logic [31:0]      tmin, tmax;
      logic             known_miss;
   } ray_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [215:0]  req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [183:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   ray_sphere_intersect dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sphere as the predictor sees it.
   logic signed [63:0] sph_cx, sph_cy, sph_cz;
   logic [63:0]        sph_r;

   hit_word_type pending_hits[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  quiet_sink = 1'b0;
   bit  timed_out = 1'b0;

   // Round a Q.32 value to Q.16, halves up.
   function automatic logic signed [127:0] round_q16(input logic signed [127:0] x);
      return (x + 128'sd32768) >>> 16;
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'h7fffffff;
      if (x < -128'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
      logic [127:0] s, c;
      s = 0;
      for (int b = 55; b >= 0; b--) begin
         c = s | (128'd1 << b);
         if (c * c <= v) s = c;
      end
      return s;
   endfunction

   // Build the hit word for parameter t.
   function automatic hit_word_type sphere_hit(input logic signed [127:0] o[3],
         input logic signed [127:0] d[3], input logic signed [127:0] t, input logic lst);
      hit_word_type w;
      logic signed [127:0] cen[3], p[3], n[3], num, q, dot;
      logic [127:0] m;
      cen[0] = sph_cx; cen[1] = sph_cy; cen[2] = sph_cz;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
         p[k] = o[k] + round_q16(t * d[k]);
         num = (p[k] - cen[k]) * 65536;
         m = num < 0 ? -num : num;
         q = (m + sph_r / 2) / sph_r;
         if (num < 0) q = -q;
         if (q > 65536) q = 65536;
         if (q < -65536) q = -65536;
         n[k] = q;
         dot += d[k] * q;
      end
      w.hit = 1'b1;
      w.front = dot < 0;
      w.hit_dist = clamp32(t);
      w.px = clamp32(p[0]); w.py = clamp32(p[1]); w.pz = clamp32(p[2]);
      w.nx = w.front ? n[0][17:0] : -n[0][17:0];
      w.ny = w.front ? n[1][17:0] : -n[1][17:0];
      w.nz = w.front ? n[2][17:0] : -n[2][17:0];
      w.last = lst;
      return w;
   endfunction

   function automatic hit_word_type miss_word();
      hit_word_type w;
      w = '{default: '0};
      w.last = 1'b1;
      return w;
   endfunction

   // Queue the expected result words of one ray.
   task automatic predict_ray(input ray_row_type r);
      logic signed [127:0] o[3], d[3], oc[3], hb, sq, disc, s, tn, tf, tlo, thi;
      o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
      d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
      tlo = $signed(r.tmin); thi = $signed(r.tmax);
      if (sph_r == 0) begin
         pending_hits.push_back(miss_word());
         return;
      end
      oc[0] = o[0] - sph_cx; oc[1] = o[1] - sph_cy; oc[2] = o[2] - sph_cz;
      hb = 0; sq = 0;
      for (int k = 0; k < 3; k++) begin
         hb += oc[k] * d[k];
         sq += oc[k] * oc[k];
      end
      disc = hb * hb + ((sph_r * sph_r) << 32) - (sq << 32);
      if (disc < 0) begin
         pending_hits.push_back(miss_word());
         return;
      end
      s = floor_sqrt(disc);
      tn = round_q16(-hb - s);
      tf = round_q16(-hb + s);
      if (r.cmd == rsi_pkg::CMD_INTERVAL) begin
         pending_hits.push_back(sphere_hit(o, d, tn, 1'b0));
         pending_hits.push_back(sphere_hit(o, d, tf, 1'b1));
      end else if (tn >= tlo && tn <= thi) begin
         pending_hits.push_back(sphere_hit(o, d, tn, 1'b1));
      end else if (tf >= tlo && tf <= thi) begin
         pending_hits.push_back(sphere_hit(o, d, tf, 1'b1));
      end else begin
         pending_hits.push_back(miss_word());
      end
   endtask

   // Send one ray, at times after a random gap, unless idling is off.
   task automatic send_ray(input ray_row_type r, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tdata <= {8'h00, r.tmax, r.tmin, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
      req_tuser <= r.cmd;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ray(r);
   endtask

   // Wait for every outstanding word, then let the pipeline drain.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rsi_pkg::REG_CENTER_X: sph_cx = $signed(val);
         rsi_pkg::REG_CENTER_Y: sph_cy = $signed(val);
         rsi_pkg::REG_CENTER_Z: sph_cz = $signed(val);
         rsi_pkg::REG_RADIUS:   sph_r = val[30:0];
         default: ;
      endcase
   endtask

   task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
         input logic [31:0] cz, input logic [31:0] rad);
      drain();
      write_reg(rsi_pkg::REG_CENTER_X, cx);
      write_reg(rsi_pkg::REG_CENTER_Y, cy);
      write_reg(rsi_pkg::REG_CENTER_Z, cz);
      write_reg(rsi_pkg::REG_RADIUS, rad);
      csr_valid <= 1'b0;
   endtask

   // Random unit-ish direction component, sometimes extreme.
   function automatic logic [17:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return 18'h20000 | 18'($urandom);
         default: return 18'($signed($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord(input int span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // Ray mostly aimed roughly at the sphere center, else in a random direction.
   function automatic ray_row_type rand_ray();
      ray_row_type r;
      logic [17:0] dd;
      r.cmd = 1'($urandom_range(0, 1));
      r.ox = 32'(sph_cx + $signed(rand_coord(6 * 65536)));
      r.oy = 32'(sph_cy + $signed(rand_coord(6 * 65536)));
      r.oz = 32'(sph_cz + $signed(rand_coord(6 * 65536)));
      if ($urandom_range(0, 3) != 0) begin
         // Point along one axis toward the center so that hits are common.
         dd = ($signed(r.ox) > $signed(sph_cx[31:0])) ? -18'sd65536 : 18'sd65536;
         r.oy = 32'(sph_cy + $signed(rand_coord(sph_r > 0 ? int'(sph_r[30:0] >> 1) : 1)));
         r.oz = 32'(sph_cz + $signed(rand_coord(sph_r > 0 ? int'(sph_r[30:0] >> 1) : 1)));
         r.dx = dd; r.dy = 18'($signed($urandom_range(0, 4000)) - 2000); r.dz = '0;
      end else begin
         r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
      end
      r.tmin = $urandom_range(0, 1) ? 32'd0 : $urandom;
      r.tmax = $urandom_range(0, 1) ? 32'h7fffffff : rand_coord(10 * 65536);
      r.known_miss = 1'b0;
      return r;
   endfunction

   // Result side: stall bursts, compare each word with the oldest expectation.
   always @(posedge clock) begin
      hit_word_type exp_w, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit_dist = rsp_tdata[31:0];
            got.px = rsp_tdata[63:32]; got.py = rsp_tdata[95:64];
            got.pz = rsp_tdata[127:96];
            got.nx = rsp_tdata[145:128]; got.ny = rsp_tdata[163:146];
            got.nz = rsp_tdata[181:164];
            got.front = rsp_tdata[182];
            got.hit = rsp_tuser; got.last = rsp_tlast;
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
               exp_w = pending_hits.pop_front();
               if (got != exp_w) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", exp_w, got);
               end
            end
         end
         if (quiet_sink) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         timed_out = 1'b1;
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Directed rays against the unit sphere at the origin.
   ray_row_type directed[] = '{
      // Along x from -3: closest hit at t = 2.
      '{rsi_pkg::CMD_CLOSEST, 32'hfffd0000, 0, 0, 18'sd65536, 0, 0, 0, 32'h7fffffff, 1'b0},
      '{rsi_pkg::CMD_INTERVAL, 32'hfffd0000, 0, 0, 18'sd65536, 0, 0, 0, 0, 1'b0},
      // Clear miss far off axis.
      '{rsi_pkg::CMD_CLOSEST, 32'hfffd0000, 32'h00050000, 0, 18'sd65536, 0, 0, 0,
        32'h7fffffff, 1'b1},
      '{rsi_pkg::CMD_INTERVAL, 32'hfffd0000, 32'h00050000, 0, 18'sd65536, 0, 0, 0, 0, 1'b1},
      // Tangent ray.
      '{rsi_pkg::CMD_INTERVAL, 32'hfffd0000, 32'h00010000, 0, 18'sd65536, 0, 0, 0, 0, 1'b0},
      // From inside: near root behind, far root in window.
      '{rsi_pkg::CMD_CLOSEST, 0, 0, 0, 0, 18'sd65536, 0, 0, 32'h7fffffff, 1'b0},
      // Window excludes both roots.
      '{rsi_pkg::CMD_CLOSEST, 32'hfffd0000, 0, 0, 18'sd65536, 0, 0, 32'h00100000,
        32'h7fffffff, 1'b1},
      // Hit behind the origin, window over negative t.
      '{rsi_pkg::CMD_CLOSEST, 32'h00030000, 0, 0, 18'sd65536, 0, 0, 32'h80000000, 0, 1'b0},
      // Extremes of origin and direction fields.
      '{rsi_pkg::CMD_CLOSEST, 32'h80000000, 32'h7fffffff, 32'h80000000, -18'sd65536,
        18'sd65536, -18'sd65536, 32'h80000000, 32'h7fffffff, 1'b0},
      '{rsi_pkg::CMD_INTERVAL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h1ffff,
        18'h20000, 18'h3ffff, 32'hffffffff, 32'h7fffffff, 1'b0},
      // Grazing start point on the surface, direction tangent.
      '{rsi_pkg::CMD_INTERVAL, 0, 32'h00010000, 0, 18'sd65536, 0, 0, 0, 0, 1'b0},
      // Non-unit direction.
      '{rsi_pkg::CMD_INTERVAL, 32'hfffd0000, 0, 0, 18'sd32768, 0, 0, 0, 0, 1'b0},
      '{rsi_pkg::CMD_CLOSEST, 32'hfffd0000, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 1'b1}
   };

   // Stimulus.
   initial begin
      sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = 65536;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: typed misses are checked as such, the rest predicted.
      foreach (directed[i]) begin
         send_ray(directed[i], 1'b1);
         if (directed[i].known_miss && pending_hits[$] != miss_word()) begin
            mismatches++;
            $display("directed row %0d should miss", i);
         end
      end

      // Wide sphere off center, then the smallest radius, then zero radius.
      set_sphere(32'h7fff0000, 32'h80000000, 32'h00020000, 32'h7fffffff);
      for (int i = 0; i < 20; i++) send_ray(rand_ray(), 1'b1);
      set_sphere(32'hffff8000, 32'h00004000, 32'h80000000, 32'd1);
      for (int i = 0; i < 20; i++) send_ray(rand_ray(), 1'b1);
      set_sphere(0, 0, 0, 0);
      for (int i = 0; i < 10; i++) send_ray(rand_ray(), 1'b1);

      // Random phases over several spheres; the last is free of idling.
      for (int ph = 0; ph < 6; ph++) begin
         set_sphere(rand_coord(20 * 65536), rand_coord(20 * 65536),
                    rand_coord(20 * 65536), $urandom_range(4096, 8 * 65536));
         if (ph == 5) quiet_sink = 1'b1;
         for (int i = 0; i < RANDOM_RAYS / 6; i++) send_ray(rand_ray(), ph != 5);
      end

      drain();
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rsi_pkg.sv
rtl/rsi_sqrt_stage.sv
rtl/rsi_div_stage.sv
rtl/rsi_hit_lane.sv
rtl/ray_sphere_intersect.sv
bench/ray_sphere_intersect_tb.sv
